/* rtl/sdis_pkg.sv */
package sdis_pkg;

  // Item layout
  localparam int unsigned InDataW  = 24;
  localparam int unsigned InUserW  = 1;
  localparam int unsigned OutDataW = 48;
  localparam int unsigned OutUserW = 2;

  // Configuration register indexes
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgAddrW-1:0] REG_POWER_UP_DELAY = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_CMD_ATTEMPTS   = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_OP_ATTEMPTS    = 2'd2;

  localparam logic [15:0] POWER_UP_DELAY_RST = 16'd1;
  localparam logic [7:0]  CMD_ATTEMPTS_RST   = 8'd2;
  localparam logic [9:0]  OP_ATTEMPTS_RST    = 10'd1000;

  // Event kinds
  localparam logic OP_START    = 1'b0;
  localparam logic OP_COMPLETE = 1'b1;

  // Result actions
  typedef logic [1:0] action_t;
  localparam action_t ACT_ISSUE   = 2'd0;
  localparam action_t ACT_DONE    = 2'd1;
  localparam action_t ACT_FAIL    = 2'd2;
  localparam action_t ACT_IGNORED = 2'd3;

  // Error classes
  typedef logic [2:0] err_t;
  localparam err_t ERR_NONE        = 3'd0;
  localparam err_t ERR_CMD_CRC     = 3'd1;
  localparam err_t ERR_RESP_CRC    = 3'd2;
  localparam err_t ERR_GENERAL     = 3'd3;
  localparam err_t ERR_NO_RESPONSE = 3'd4;
  localparam err_t ERR_UNSUPPORTED = 3'd5;
  localparam err_t ERR_OTHER_LO    = 3'd6;
  localparam err_t ERR_OTHER_HI    = 3'd7;

  // Commands in issue order
  typedef logic [3:0] cmd_t;
  localparam cmd_t CMD_CMD0   = 4'd0;
  localparam cmd_t CMD_CMD8   = 4'd1;
  localparam cmd_t CMD_ACMD41 = 4'd2;
  localparam cmd_t CMD_CMD2   = 4'd3;
  localparam cmd_t CMD_CMD3   = 4'd4;
  localparam cmd_t CMD_CMD9   = 4'd5;
  localparam cmd_t CMD_CMD7   = 4'd6;
  localparam cmd_t CMD_ACMD42 = 4'd7;
  localparam cmd_t CMD_ACMD6  = 4'd8;

  // Sequencer phase: idle, waiting for command n (n+1), done, failed
  typedef logic [3:0] phase_t;
  localparam phase_t PH_IDLE     = 4'd0;
  localparam phase_t PH_WAIT_LO  = 4'd1;
  localparam phase_t PH_WAIT_HI  = 4'd9;
  localparam phase_t PH_DONE     = 4'd10;
  localparam phase_t PH_FAILED   = 4'd11;

  // Interface clock state
  typedef logic [1:0] clk_mode_t;
  localparam clk_mode_t CLK_OFF  = 2'd0;
  localparam clk_mode_t CLK_SLOW = 2'd1;
  localparam clk_mode_t CLK_FAST = 2'd2;

  typedef struct packed {
    logic [15:0] power_up_delay_ms;
    logic [7:0]  command_attempt_limit;
    logic [9:0]  op_cond_attempt_limit;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [9:0]  attempts_left;
    logic        capacity_flag;
    logic [15:0] card_address;
  } state_t;

  typedef struct packed {
    logic        opcode;
    err_t        error_class;
    logic        card_ready;
    logic        csd_supported;
    logic [15:0] new_card_address;
  } item_t;

  typedef struct packed {
    action_t     action;
    cmd_t        command;
    logic [15:0] delay_ms;
    logic        high_capacity;
    logic [15:0] card_address;
    err_t        fail_code;
    clk_mode_t   clock_mode;
    logic        wide_bus;
  } result_t;

endpackage

/* rtl/sdis_cfg_regs.sv */
module sdis_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [sdis_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [sdis_pkg::CfgDataW-1:0] cfg_wdata,
  output sdis_pkg::cfg_t               cfg
);
  import sdis_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.power_up_delay_ms     <= POWER_UP_DELAY_RST;
      cfg_r.command_attempt_limit <= CMD_ATTEMPTS_RST;
      cfg_r.op_cond_attempt_limit <= OP_ATTEMPTS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_POWER_UP_DELAY: cfg_r.power_up_delay_ms     <= cfg_wdata;
        REG_CMD_ATTEMPTS:   cfg_r.command_attempt_limit <= cfg_wdata[7:0];
        REG_OP_ATTEMPTS:    cfg_r.op_cond_attempt_limit <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/sdis_step.sv */
// Next-state and result decision for one event.
module sdis_step (
  input  sdis_pkg::cfg_t    cfg,
  input  sdis_pkg::state_t  st,
  input  sdis_pkg::item_t   item,
  output sdis_pkg::state_t  st_nxt,
  output sdis_pkg::result_t res
);
  import sdis_pkg::*;

  logic       waiting;
  cmd_t       cur_cmd;
  logic [9:0] att_dec;
  logic       can_retry;
  logic       general;
  logic       do_issue;
  logic       do_fail;
  logic       do_done;
  cmd_t       issue_cmd;
  logic [15:0] issue_delay;
  err_t       fail_code;

  assign waiting   = (st.phase >= PH_WAIT_LO) && (st.phase <= PH_WAIT_HI);
  assign cur_cmd   = st.phase - 4'd1;
  assign att_dec   = (st.attempts_left != '0) ? st.attempts_left - 10'd1 : '0;
  // one more try only if budget remains and the error class is retryable
  assign can_retry = (st.attempts_left > 10'd1) && (item.error_class <= ERR_GENERAL);

  always_comb begin
    st_nxt      = st;
    general     = 1'b0;
    do_issue    = 1'b0;
    do_fail     = 1'b0;
    do_done     = 1'b0;
    issue_cmd   = CMD_CMD0;
    issue_delay = '0;
    fail_code   = ERR_NONE;

    if (item.opcode == OP_START) begin
      st_nxt.attempts_left = '0;
      do_issue    = 1'b1;
      issue_cmd   = CMD_CMD0;
      issue_delay = cfg.power_up_delay_ms;
    end else if (waiting) begin
      general = 1'b1;
      unique case (cur_cmd)
        CMD_CMD0: begin
          general = 1'b0;
          if (item.error_class != ERR_NONE) begin
            do_fail   = 1'b1;
            fail_code = item.error_class;
          end else begin
            st_nxt.attempts_left = {2'b00, cfg.command_attempt_limit};
            do_issue  = 1'b1;
            issue_cmd = CMD_CMD8;
          end
        end
        CMD_CMD8: begin
          // no answer to CMD8 means a standard-capacity card
          if (item.error_class == ERR_NONE || item.error_class == ERR_NO_RESPONSE) begin
            general = 1'b0;
            st_nxt.capacity_flag = (item.error_class == ERR_NONE);
            st_nxt.attempts_left = cfg.op_cond_attempt_limit;
            do_issue  = 1'b1;
            issue_cmd = CMD_ACMD41;
          end
        end
        CMD_ACMD41: begin
          general = 1'b0;
          if (item.error_class == ERR_NONE && item.card_ready) begin
            st_nxt.attempts_left = {2'b00, cfg.command_attempt_limit};
            do_issue  = 1'b1;
            issue_cmd = CMD_CMD2;
          end else begin
            st_nxt.attempts_left = att_dec;
            if (can_retry) begin
              do_issue    = 1'b1;
              issue_cmd   = CMD_ACMD41;
              issue_delay = 16'd1;
            end else begin
              do_fail   = 1'b1;
              fail_code = ERR_UNSUPPORTED;
            end
          end
        end
        CMD_CMD3: begin
          if (item.error_class == ERR_NONE) st_nxt.card_address = item.new_card_address;
        end
        CMD_CMD9: begin
          if (item.error_class == ERR_NONE && !item.csd_supported) begin
            general   = 1'b0;
            do_fail   = 1'b1;
            fail_code = ERR_UNSUPPORTED;
          end
        end
        default: ;
      endcase

      if (general) begin
        if (item.error_class == ERR_NONE) begin
          if (cur_cmd == CMD_ACMD6) begin
            do_done = 1'b1;
          end else begin
            st_nxt.attempts_left = {2'b00, cfg.command_attempt_limit};
            do_issue  = 1'b1;
            issue_cmd = cur_cmd + 4'd1;
          end
        end else begin
          st_nxt.attempts_left = att_dec;
          if (can_retry) begin
            do_issue  = 1'b1;
            issue_cmd = cur_cmd;
          end else begin
            do_fail   = 1'b1;
            fail_code = item.error_class;
          end
        end
      end
    end

    if (do_issue) st_nxt.phase = issue_cmd + 4'd1;
    if (do_fail)  st_nxt.phase = PH_FAILED;
    if (do_done)  st_nxt.phase = PH_DONE;
  end

  always_comb begin
    res.action        = ACT_IGNORED;
    res.command       = CMD_CMD0;
    res.delay_ms      = '0;
    res.high_capacity = st_nxt.capacity_flag;
    res.card_address  = st_nxt.card_address;
    res.fail_code     = ERR_NONE;
    res.clock_mode    = CLK_OFF;
    res.wide_bus      = 1'b0;
    if (do_issue) begin
      res.action     = ACT_ISSUE;
      res.command    = issue_cmd;
      res.delay_ms   = issue_delay;
      res.clock_mode = CLK_SLOW;
    end else if (do_fail) begin
      res.action    = ACT_FAIL;
      res.fail_code = fail_code;
    end else if (do_done || st.phase == PH_DONE) begin
      res.action     = do_done ? ACT_DONE : ACT_IGNORED;
      res.clock_mode = CLK_FAST;
      res.wide_bus   = 1'b1;
    end
  end

endmodule

/* rtl/sd_card_init_sequencer.sv */
// SD card initialization sequencer. Send one start word (in_tuser = 0) to begin bring-up,
// then one completion word (in_tuser = 1) per finished command carrying its error class
// and, where relevant, the power-up, CSD verdict and new relative card address. Each input
// word yields exactly one output word: issue a command (with the delay in ms to wait first),
// done, failed, or ignored. Commands run CMD0, CMD8, ACMD41, CMD2, CMD3, CMD9, CMD7, ACMD42,
// ACMD6. Throughput is one word per clock unless the output stalls; each word passes
// the input register, then the next-state decision into the output register. The sequencer
// state updates as a word moves from the input register to the output register, so
// back-to-back words see each other's effects. Configuration registers are written through
// cfg_we/cfg_addr/cfg_wdata and should only change while no word is in flight.
module sd_card_init_sequencer (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration: 0 power_up_delay_ms, 1 command_attempt_limit, 2 op_cond_attempt_limit
  input  logic                           cfg_we,
  input  logic [sdis_pkg::CfgAddrW-1:0]  cfg_addr,
  input  logic [sdis_pkg::CfgDataW-1:0]  cfg_wdata,
  // events
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [2:0] error_class, [3] card_ready, [4] csd_supported, [20:5] new_card_address
  input  logic [sdis_pkg::InDataW-1:0]   in_tdata,
  // [0] opcode
  input  logic [sdis_pkg::InUserW-1:0]   in_tuser,
  // results
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [3:0] command, [19:4] delay_ms, [20] high_capacity, [36:21] card_address,
  // [39:37] fail_code, [41:40] clock_mode, [42] wide_bus
  output logic [sdis_pkg::OutDataW-1:0]  out_tdata,
  // [1:0] action
  output logic [sdis_pkg::OutUserW-1:0]  out_tuser
);
  import sdis_pkg::*;

  cfg_t    cfg;
  state_t  st_r, st_nxt;
  item_t   item_r;
  logic    in_valid_r;
  result_t res, res_r;
  logic    out_valid_r;
  logic    advance;

  sdis_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  sdis_step u_step (
    .cfg   (cfg),
    .st    (st_r),
    .item  (item_r),
    .st_nxt(st_nxt),
    .res   (res)
  );

  // a word moves from input register to output register when the output slot frees up
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '{phase: PH_IDLE, attempts_left: '0, capacity_flag: 1'b0,
                       card_address: '0};
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (advance) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.opcode           <= in_tuser[0];
      item_r.error_class      <= in_tdata[2:0];
      item_r.card_ready       <= in_tdata[3];
      item_r.csd_supported    <= in_tdata[4];
      item_r.new_card_address <= in_tdata[20:5];
    end
    if (advance) res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.action;
  assign out_tdata  = {5'b00000, res_r.wide_bus, res_r.clock_mode, res_r.fail_code,
                       res_r.card_address, res_r.high_capacity, res_r.delay_ms,
                       res_r.command};

endmodule

/* rtl/sdis_checker.sv */
module sdis_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [sdis_pkg::OutDataW-1:0] out_tdata,
  input logic [sdis_pkg::OutUserW-1:0] out_tuser
);
  import sdis_pkg::*;

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid right after reset");

  // only an issue carries a command, delay or clock-slow mode
  a_issue_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ACT_ISSUE) |->
      (out_tdata[41:40] == CLK_SLOW && !out_tdata[42] && out_tdata[39:37] == ERR_NONE))
    else $error("issue word with wrong interface mode");

  a_non_issue_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ACT_ISSUE) |-> (out_tdata[19:0] == '0))
    else $error("command or delay set on non-issue word");

  // done brings fast clock and wide bus, failure turns the clock off
  a_end_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ACT_DONE || out_tuser == ACT_FAIL)) |->
      ((out_tuser == ACT_DONE) == (out_tdata[41:40] == CLK_FAST && out_tdata[42])))
    else $error("wrong interface mode on done or fail");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result word changed");

endmodule

bind sd_card_init_sequencer sdis_checker u_sdis_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

/* sim/sd_init_checker.sv */
`timescale 1ns / 100ps

// Watches the event and result streams, runs its own copy of the bring-up
// state machine and compares every result word with the oldest prediction.
module sd_init_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sdis_pkg::CfgAddrW-1:0]   cfg_addr,
  input  logic [sdis_pkg::CfgDataW-1:0]   cfg_wdata,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // [2:0] error_class, [3] card_ready, [4] csd_supported, [20:5] new_card_address
  input  logic [sdis_pkg::InDataW-1:0]    in_tdata,
  // [0] opcode
  input  logic [sdis_pkg::InUserW-1:0]    in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // [3:0] command, [19:4] delay_ms, [20] high_capacity, [36:21] card_address,
  // [39:37] fail_code, [41:40] clock_mode, [42] wide_bus
  input  logic [sdis_pkg::OutDataW-1:0]   out_tdata,
  // [1:0] action
  input  logic [sdis_pkg::OutUserW-1:0]   out_tuser,
  output int                              fail_count,
  output int                              pending_words
);
  import sdis_pkg::*;

  localparam logic [15:0] OP_COND_RETRY_MS = 16'd1;

  cfg_t    regs;
  state_t  seq;
  result_t expected_words[$];
  int      errs = 0;

  function automatic result_t pack_word(action_t act, cmd_t cmd, logic [15:0] dly,
                                        err_t code, clk_mode_t mode, logic wide);
    result_t w;
    w.action        = act;
    w.command       = cmd;
    w.delay_ms      = dly;
    w.high_capacity = seq.capacity_flag;
    w.card_address  = seq.card_address;
    w.fail_code     = code;
    w.clock_mode    = mode;
    w.wide_bus      = wide;
    return w;
  endfunction

  function automatic result_t issue_cmd(cmd_t cmd, logic [15:0] dly);
    seq.phase = phase_t'(cmd + 1);
    return pack_word(ACT_ISSUE, cmd, dly, ERR_NONE, CLK_SLOW, 1'b0);
  endfunction

  function automatic result_t abort_seq(err_t code);
    seq.phase = PH_FAILED;
    return pack_word(ACT_FAIL, CMD_CMD0, '0, code, CLK_OFF, 1'b0);
  endfunction

  // burns one attempt; true while the budget and error class allow a retry
  function automatic logic spend_attempt(err_t err);
    logic more;
    more = seq.attempts_left > 10'd1;
    if (seq.attempts_left != '0) seq.attempts_left = seq.attempts_left - 10'd1;
    return more && (err <= ERR_GENERAL);
  endfunction

  function automatic result_t next_word(item_t ev);
    cmd_t cur;
    if (ev.opcode == OP_START) begin
      seq.attempts_left = '0;
      return issue_cmd(CMD_CMD0, regs.power_up_delay_ms);
    end
    if (seq.phase == PH_DONE)
      return pack_word(ACT_IGNORED, CMD_CMD0, '0, ERR_NONE, CLK_FAST, 1'b1);
    if (seq.phase < PH_WAIT_LO || seq.phase > PH_WAIT_HI)
      return pack_word(ACT_IGNORED, CMD_CMD0, '0, ERR_NONE, CLK_OFF, 1'b0);

    cur = cmd_t'(seq.phase - PH_WAIT_LO);
    case (cur)
      CMD_CMD0: begin
        if (ev.error_class != ERR_NONE) return abort_seq(ev.error_class);
        seq.attempts_left = 10'(regs.command_attempt_limit);
        return issue_cmd(CMD_CMD8, '0);
      end
      CMD_CMD8: begin
        // no response to CMD8 means a standard-capacity card
        if (ev.error_class == ERR_NONE || ev.error_class == ERR_NO_RESPONSE) begin
          seq.capacity_flag = (ev.error_class == ERR_NONE);
          seq.attempts_left = regs.op_cond_attempt_limit;
          return issue_cmd(CMD_ACMD41, '0);
        end
      end
      CMD_ACMD41: begin
        if (ev.error_class == ERR_NONE && ev.card_ready) begin
          seq.attempts_left = 10'(regs.command_attempt_limit);
          return issue_cmd(CMD_CMD2, '0);
        end
        if (spend_attempt(ev.error_class)) return issue_cmd(CMD_ACMD41, OP_COND_RETRY_MS);
        return abort_seq(ERR_UNSUPPORTED);
      end
      CMD_CMD3: begin
        if (ev.error_class == ERR_NONE) seq.card_address = ev.new_card_address;
      end
      CMD_CMD9: begin
        if (ev.error_class == ERR_NONE && !ev.csd_supported) return abort_seq(ERR_UNSUPPORTED);
      end
      default: ;
    endcase

    if (ev.error_class == ERR_NONE) begin
      if (cur == CMD_ACMD6) begin
        seq.phase = PH_DONE;
        return pack_word(ACT_DONE, CMD_CMD0, '0, ERR_NONE, CLK_FAST, 1'b1);
      end
      seq.attempts_left = 10'(regs.command_attempt_limit);
      return issue_cmd(cmd_t'(cur + 1), '0);
    end
    if (spend_attempt(ev.error_class)) return issue_cmd(cur, '0);
    return abort_seq(ev.error_class);
  endfunction

  task automatic check_field(string label, int unsigned want, int unsigned seen);
    if (want != seen) begin
      if (errs < 10)
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, label, want, seen);
      errs++;
    end
  endtask

  always @(posedge clk) begin : watch
    item_t   ev;
    result_t want;
    result_t seen;
    if (!rst_n) begin
      regs.power_up_delay_ms     = POWER_UP_DELAY_RST;
      regs.command_attempt_limit = CMD_ATTEMPTS_RST;
      regs.op_cond_attempt_limit = OP_ATTEMPTS_RST;
      seq.phase                  = PH_IDLE;
      seq.attempts_left          = '0;
      seq.capacity_flag          = 1'b0;
      seq.card_address           = '0;
      expected_words.delete();
    end else begin
      // results first: a word accepted now cannot be answered in the same cycle
      if (out_tvalid && out_tready) begin
        seen.action        = out_tuser[1:0];
        seen.command       = out_tdata[3:0];
        seen.delay_ms      = out_tdata[19:4];
        seen.high_capacity = out_tdata[20];
        seen.card_address  = out_tdata[36:21];
        seen.fail_code     = out_tdata[39:37];
        seen.clock_mode    = out_tdata[41:40];
        seen.wide_bus      = out_tdata[42];
        if (expected_words.size() == 0) begin
          if (errs < 10)
            $display("%0t: unexpected result word 0x%0h/0x%0h", $time, out_tuser, out_tdata);
          errs++;
        end else begin
          want = expected_words.pop_front();
          check_field("action", want.action, seen.action);
          check_field("command", want.command, seen.command);
          check_field("delay_ms", want.delay_ms, seen.delay_ms);
          check_field("high_capacity", want.high_capacity, seen.high_capacity);
          check_field("card_address", want.card_address, seen.card_address);
          check_field("fail_code", want.fail_code, seen.fail_code);
          check_field("clock_mode", want.clock_mode, seen.clock_mode);
          check_field("wide_bus", want.wide_bus, seen.wide_bus);
        end
      end

      if (in_tvalid && in_tready) begin
        ev.opcode           = in_tuser[0];
        ev.error_class      = in_tdata[2:0];
        ev.card_ready       = in_tdata[3];
        ev.csd_supported    = in_tdata[4];
        ev.new_card_address = in_tdata[20:5];
        want = next_word(ev);
        expected_words.push_back(want);
      end

      if (cfg_we) begin
        case (cfg_addr)
          REG_POWER_UP_DELAY: regs.power_up_delay_ms     = cfg_wdata;
          REG_CMD_ATTEMPTS:   regs.command_attempt_limit = cfg_wdata[7:0];
          REG_OP_ATTEMPTS:    regs.op_cond_attempt_limit = cfg_wdata[9:0];
          default: ;
        endcase
      end
    end
    fail_count    <= errs;
    pending_words <= expected_words.size();
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps

// Bring-up sequencer bench: drives start/completion words with random gaps,
// lets the result side stall at random, and leaves prediction and compare to
// the checker beside the block.
module testbench;
  import sdis_pkg::*;

  // cycles with no handshake and no register write before giving up; the
  // slowest legal stretch is a few gap/stall bursts plus the drain waits
  localparam int StallLimit = 2000;
  localparam int PhaseWords = 192;   // minimum input words per config setting
  localparam int NumPhases  = 7;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                cfg_we     = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr   = '0;
  logic [CfgDataW-1:0] cfg_wdata  = '0;
  logic                in_tvalid  = 1'b0;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic [InUserW-1:0]  in_tuser   = '0;
  logic                out_tready = 1'b0;
  wire                 in_tready;
  wire                 out_tvalid;
  wire [OutDataW-1:0]  out_tdata;
  wire [OutUserW-1:0]  out_tuser;

  int   fail_count;
  int   pending_words;
  int   sink_stall  = 0;
  int   idle_cycles = 0;
  logic calm        = 1'b0;  // final stretch: no gaps, no stalls
  logic steady      = 1'b0;  // current run goes without gaps/stalls

  always #4 clk = ~clk;

  sd_card_init_sequencer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  sd_init_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  // Result side: random stall bursts
  always @(posedge clk) begin
    if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      out_tready <= 1'b0;
    end else if (!calm && !steady && $urandom_range(0, 5) == 0) begin
      sink_stall <= $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One event word; returns in the time step of its acceptance edge.
  task automatic send_word(logic op, err_t err, logic pwr, logic csd, logic [15:0] addr);
    if (!calm && !steady && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, addr, csd, pwr, err};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_start();
    send_word(OP_START, err_t'($urandom_range(ERR_NONE, ERR_OTHER_HI)), 1'($urandom),
              1'($urandom), 16'($urandom));
  endtask

  // Completion mostly clean; CMD8 no-response and retryable classes weighted up
  task automatic send_completion();
    int   pick;
    err_t err;
    pick = $urandom_range(0, 99);
    if (pick < 72)      err = ERR_NONE;
    else if (pick < 80) err = ERR_NO_RESPONSE;
    else if (pick < 92) err = err_t'($urandom_range(ERR_CMD_CRC, ERR_GENERAL));
    else                err = err_t'($urandom_range(ERR_UNSUPPORTED, ERR_OTHER_HI));
    send_word(OP_COMPLETE, err, $urandom_range(0, 99) < 65, $urandom_range(0, 99) < 92,
              16'($urandom));
  endtask

  // Drop valid, wait until every expected word is back, then let the pipe settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(logic [15:0] delay, logic [7:0] cmd_lim, logic [9:0] op_lim);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_POWER_UP_DELAY;
    cfg_wdata <= delay;
    @(posedge clk);
    cfg_addr  <= REG_CMD_ATTEMPTS;
    cfg_wdata <= 16'(cmd_lim);
    @(posedge clk);
    cfg_addr  <= REG_OP_ATTEMPTS;
    cfg_wdata <= 16'(op_lim);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Bring-up attempts: a start, then a run of completions; a few noise words
  task automatic random_traffic(int target);
    int sent;
    int run_len;
    sent = 0;
    while (sent < target) begin
      steady  = ($urandom_range(0, 4) == 0);
      run_len = $urandom_range(2, 14);
      send_start();
      repeat (run_len) begin
        if ($urandom_range(0, 24) == 0)
          send_word(1'($urandom), err_t'($urandom_range(ERR_NONE, ERR_OTHER_HI)),
                    1'($urandom), 1'($urandom), 16'($urandom));
        else
          send_completion();
      end
      sent += run_len + 1;
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk with reset config (delay 1, 2 attempts, 1000 op-cond attempts)
    send_word(OP_COMPLETE, ERR_OTHER_HI, 1'b1, 1'b1, 16'hFFFF);   // idle after reset: ignored
    send_word(OP_START, ERR_OTHER_HI, 1'b1, 1'b1, 16'hFFFF);      // CMD0 after power-up delay
    send_word(OP_COMPLETE, ERR_NONE, 1'b0, 1'b0, 16'h0000);       // -> CMD8
    send_word(OP_COMPLETE, ERR_NO_RESPONSE, 1'b0, 1'b0, '0);      // standard capacity -> ACMD41
    send_word(OP_COMPLETE, ERR_NONE, 1'b0, 1'b0, '0);             // still busy: ACMD41 again
    send_word(OP_COMPLETE, ERR_RESP_CRC, 1'b1, 1'b0, '0);         // resp crc: ACMD41 again
    send_word(OP_COMPLETE, ERR_NONE, 1'b1, 1'b0, '0);             // powered up -> CMD2
    send_word(OP_COMPLETE, ERR_CMD_CRC, 1'b0, 1'b0, '0);          // cmd crc: retry CMD2
    send_word(OP_COMPLETE, ERR_CMD_CRC, 1'b0, 1'b0, '0);          // budget spent: failed
    send_word(OP_START, ERR_NONE, 1'b0, 1'b0, '0);                // restart after failure
    send_word(OP_COMPLETE, ERR_NONE, 1'b0, 1'b0, '0);             // -> CMD8
    send_word(OP_COMPLETE, ERR_NONE, 1'b0, 1'b0, '0);             // high capacity -> ACMD41
    send_word(OP_COMPLETE, ERR_NONE, 1'b1, 1'b0, '0);             // -> CMD2
    send_word(OP_COMPLETE, ERR_NONE, 1'b0, 1'b0, '0);             // -> CMD3
    send_word(OP_COMPLETE, ERR_GENERAL, 1'b0, 1'b0, 16'h1234);    // error: address not taken
    send_word(OP_COMPLETE, ERR_NONE, 1'b0, 1'b0, 16'hA5C3);       // address stored -> CMD9
    send_word(OP_COMPLETE, ERR_NONE, 1'b0, 1'b1, '0);             // card supported -> CMD7
    send_word(OP_COMPLETE, ERR_NONE, 1'b0, 1'b0, '0);             // -> ACMD42
    send_word(OP_COMPLETE, ERR_NONE, 1'b0, 1'b0, '0);             // -> ACMD6
    send_word(OP_COMPLETE, ERR_NONE, 1'b0, 1'b0, '0);             // done, fast 4-bit
    send_word(OP_COMPLETE, ERR_OTHER_LO, 1'b1, 1'b1, 16'hFFFF);   // after done: ignored
    send_word(OP_START, ERR_NONE, 1'b0, 1'b0, '0);                // restart from done
    send_word(OP_COMPLETE, ERR_OTHER_LO, 1'b0, 1'b0, '0);         // CMD0 error fails at once
    send_word(OP_START, ERR_NONE, 1'b0, 1'b0, '0);
    send_word(OP_COMPLETE, ERR_NONE, 1'b0, 1'b0, '0);             // -> CMD8
    send_word(OP_COMPLETE, ERR_UNSUPPORTED, 1'b0, 1'b0, '0);      // CMD8 unsupported: failed

    // Random bring-up traffic under a series of register settings
    for (int p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1: program_regs(16'd0, 8'd1, 10'd1);
          2: program_regs(16'hFFFF, 8'd255, 10'd1023);
          3: program_regs(16'($urandom), 8'($urandom_range(1, 4)),
                          10'($urandom_range(2, 5)));
          6: program_regs(POWER_UP_DELAY_RST, CMD_ATTEMPTS_RST, OP_ATTEMPTS_RST);
          default: program_regs(16'($urandom), 8'($urandom_range(1, 255)),
                                10'($urandom_range(1, 1023)));
        endcase
      end
      calm = (p == NumPhases - 1);
      random_traffic(PhaseWords);
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
